FILE: hw/rtl/keyframe_color_lerp_defines.svh
// ----------------------------------------------------------------------------
// keyframe_color_lerp assertion macros
// Shared assertion forms for the keyframe color interpolator checkers.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_COLOR_LERP_DEFINES_SVH
`define KEYFRAME_COLOR_LERP_DEFINES_SVH

// same-cycle implication
`define KCL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KCL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/kcl_pkg.sv
// ----------------------------------------------------------------------------
// kcl_pkg
// Types and constants shared by the keyframe color interpolator.
// ----------------------------------------------------------------------------
package kcl_pkg;

    localparam int MAX_KEYS_DEF = 64;
    localparam int POS_W        = 16;
    localparam int FRAME_W      = 32;
    localparam int CHAN_N       = 9;
    localparam int PROD_W       = 24;
    localparam int IN_DATA_W    = 128;
    localparam int OUT_DATA_W   = 72;
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_FRAMES = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEYS_IN_USE = 4'd1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam logic [15:0] LOOP_FRAMES_RST = 16'd1;
    localparam logic [6:0]  KEYS_IN_USE_RST = 7'd2;

    // one keyframe: prim is r,g,b,a,lod high to low; env is r,g,b,a
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [39:0]      prim;
        logic [31:0]      env;
    } t_key;

    typedef struct packed {
        logic start;
        logic step;
    } t_lane_ctl;

    typedef struct packed {
        logic [15:0] num_mag;
        logic [15:0] span_mag;
        logic        neg;
    } t_lane_op;

endpackage

FILE: hw/rtl/keyframe_color_lerp.sv
// ----------------------------------------------------------------------------
// keyframe_color_lerp
// Piecewise linear keyframe color interpolation over a ring of key cells.
// ----------------------------------------------------------------------------
//  channel  dir  handshake               payload
//  s        in   i_s_tvalid/o_s_tready   i_s_tdata (entry/frame), i_s_tuser (op)
//  m        out  o_m_tvalid/i_m_tready   o_m_tdata (nine 8-bit channels)
//  cfg      in   i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
//  Load: no result; the input stays ready. Evaluate: ready returns after
//  a 32-step modulo, one ring rotation of MAX_KEYS cells past the
//  compare head, a 24-step divide in nine parallel lanes and the output load.
//  Synchronous active-low reset clears control state; the key table is
//  undefined until loaded. A pending result in the output register does
//  not block the next item; only a new result waits for it.
// ----------------------------------------------------------------------------
module keyframe_color_lerp #(
    parameter int MAX_KEYS = kcl_pkg::MAX_KEYS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // [5:0] entry_index, [21:6] entry_position, [53:22] entry_prim_rgba,
    // [61:54] entry_prim_lod, [93:62] entry_env_rgba, [125:94] frame_number
    input  logic [kcl_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // [0] operation
    input  logic                             i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [7:0] prim_red, prim_green, prim_blue, prim_alpha, prim_lod,
    // env_red, env_green, env_blue, [71:64] env_alpha
    output logic [kcl_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [kcl_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [kcl_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int KW        = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CW        = ((KW > 7) ? KW : 7) + 1;
    localparam int CNT_W     = (KW > 5) ? KW : 5;
    localparam int MOD_LAST  = kcl_pkg::FRAME_W - 1;
    localparam int DIV_LAST  = kcl_pkg::PROD_W - 1;
    localparam int SRCH_LAST = MAX_KEYS - 1;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_MOD    = 7'b0000010,
        ST_SEARCH = 7'b0000100,
        ST_PREP   = 7'b0001000,
        ST_LANE   = 7'b0010000,
        ST_DIV    = 7'b0100000,
        ST_OUT    = 7'b1000000
    } t_state;

    t_state                              r_state;
    logic [CNT_W-1:0]                    r_cnt;
    logic [15:0]                         r_loop;
    logic [6:0]                          r_keys;
    logic [kcl_pkg::FRAME_W-1:0]         r_frame;
    logic [15:0]                         r_t;
    logic                                r_found;
    kcl_pkg::t_key                       r_left;
    kcl_pkg::t_key                       r_right;
    kcl_pkg::t_lane_op                   r_op;
    logic                                r_out_valid;
    logic [kcl_pkg::OUT_DATA_W-1:0]      r_out_data;

    logic                                s_acc;
    logic                                load_acc;
    logic [5:0]                          entry_index;
    kcl_pkg::t_key                       wkey;
    kcl_pkg::t_key                       cell_key [MAX_KEYS];
    kcl_pkg::t_key                       head;
    logic                                ring_shift;
    logic [KW-1:0]                       k;
    logic                                in_use;
    logic                                hit;
    logic [15:0]                         len;
    logic [16:0]                         trial_m;
    logic [16:0]                         num;
    logic [16:0]                         span;
    logic                                keep;
    logic [71:0]                         left_bytes;
    logic [71:0]                         right_bytes;
    logic [kcl_pkg::OUT_DATA_W-1:0]      lane_vals;
    kcl_pkg::t_lane_ctl                  lane_ctl;

    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;

    assign s_acc       = i_s_tvalid && o_s_tready;
    assign load_acc    = s_acc && (i_s_tuser == kcl_pkg::OP_LOAD);
    assign entry_index = i_s_tdata[5:0];
    assign wkey.pos    = i_s_tdata[21:6];
    assign wkey.prim   = {i_s_tdata[53:22], i_s_tdata[61:54]};
    assign wkey.env    = i_s_tdata[93:62];

    assign ring_shift  = (r_state == ST_SEARCH);

    for (genvar j = 0; j < MAX_KEYS; j++) begin : g_cell
        logic we;
        assign we = load_acc && ({{(CW-6){1'b0}}, entry_index} == CW'(j));
        kcl_cell u_cell (
            .i_clk   (i_clk),
            .i_we    (we),
            .i_wkey  (wkey),
            .i_shift (ring_shift),
            .i_next  (cell_key[(j + 1) % MAX_KEYS]),
            .o_key   (cell_key[j])
        );
    end

    assign head = cell_key[0];

    always_comb begin
        k       = r_cnt[KW-1:0];
        in_use  = ({{(CW-KW){1'b0}}, k} < {{(CW-7){1'b0}}, r_keys});
        hit     = !r_found && (k != '0) && in_use && (r_t < head.pos);
        len     = (r_loop == 16'd0) ? 16'd1 : r_loop;
        trial_m = {r_t, r_frame[kcl_pkg::FRAME_W-1]};
        num     = {1'b0, r_t} - {1'b0, r_left.pos};
        span    = {1'b0, r_right.pos} - {1'b0, r_left.pos};
        keep    = r_found && (span != 17'd0);
    end

    assign left_bytes  = {r_left.prim, r_left.env};
    assign right_bytes = {r_right.prim, r_right.env};
    assign lane_ctl.start = (r_state == ST_LANE);
    assign lane_ctl.step  = (r_state == ST_DIV);

    for (genvar c = 0; c < kcl_pkg::CHAN_N; c++) begin : g_lane
        kcl_lane u_lane (
            .i_clk   (i_clk),
            .i_ctl   (lane_ctl),
            .i_op    (r_op),
            .i_left  (left_bytes[71-8*c -: 8]),
            .i_right (right_bytes[71-8*c -: 8]),
            .o_val   (lane_vals[8*c +: 8])
        );
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_loop      <= kcl_pkg::LOOP_FRAMES_RST;
            r_keys      <= kcl_pkg::KEYS_IN_USE_RST;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    kcl_pkg::CFG_LOOP_FRAMES: r_loop <= i_cfg_data;
                    kcl_pkg::CFG_KEYS_IN_USE: r_keys <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if ((r_state == ST_OUT) && (!r_out_valid || i_m_tready)) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    r_cnt   <= '0;
                    r_found <= 1'b0;
                    if (s_acc && (i_s_tuser == kcl_pkg::OP_EVAL)) begin
                        r_state <= ST_MOD;
                    end
                end
                ST_MOD: begin
                    if (r_cnt == CNT_W'(MOD_LAST)) begin
                        r_cnt   <= '0;
                        r_state <= ST_SEARCH;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_SEARCH: begin
                    if (hit) begin
                        r_found <= 1'b1;
                    end
                    if (r_cnt == CNT_W'(SRCH_LAST)) begin
                        r_cnt   <= '0;
                        r_state <= ST_PREP;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_PREP: r_state <= ST_LANE;
                ST_LANE: begin
                    r_cnt   <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(DIV_LAST)) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_frame <= i_s_tdata[125:94];
            r_t     <= '0;
        end
        if (r_state == ST_MOD) begin
            r_t     <= (trial_m >= {1'b0, len}) ? 16'(trial_m - {1'b0, len})
                                                 : trial_m[15:0];
            r_frame <= {r_frame[kcl_pkg::FRAME_W-2:0], 1'b0};
        end
        if (r_state == ST_SEARCH) begin
            if (hit) begin
                r_right <= head;
            end else if (!r_found && ((k == '0) || in_use)) begin
                r_left <= head;
            end
        end
        if (r_state == ST_PREP) begin
            if (keep) begin
                r_op.num_mag  <= num[16] ? 16'(~num + 17'd1) : num[15:0];
                r_op.span_mag <= span[16] ? 16'(~span + 17'd1) : span[15:0];
                r_op.neg      <= num[16] ^ span[16];
            end else begin
                r_op.num_mag  <= 16'd0;
                r_op.span_mag <= 16'd1;
                r_op.neg      <= 1'b0;
                r_right       <= r_left;
            end
        end
        if ((r_state == ST_OUT) && (!r_out_valid || i_m_tready)) begin
            r_out_data <= lane_vals;
        end
    end

endmodule

FILE: hw/rtl/kcl_cell.sv
// ----------------------------------------------------------------------------
// kcl_cell
// One keyframe slot of the key ring; loads directly or takes its neighbor.
// ----------------------------------------------------------------------------
module kcl_cell (
    input  logic          i_clk,
    input  logic          i_we,
    input  kcl_pkg::t_key i_wkey,
    input  logic          i_shift,
    input  kcl_pkg::t_key i_next,
    output kcl_pkg::t_key o_key
);

    kcl_pkg::t_key r_key;
    kcl_pkg::t_key n_key;

    always_comb begin
        n_key = r_key;
        if (i_we) begin
            n_key = i_wkey;
        end else if (i_shift) begin
            n_key = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_key = r_key;

endmodule

FILE: hw/rtl/kcl_lane.sv
// ----------------------------------------------------------------------------
// kcl_lane
// One 8-bit channel: |diff|*|num| product, then restoring divide by span.
// ----------------------------------------------------------------------------
module kcl_lane (
    input  logic               i_clk,
    input  kcl_pkg::t_lane_ctl i_ctl,
    input  kcl_pkg::t_lane_op  i_op,
    input  logic [7:0]         i_left,
    input  logic [7:0]         i_right,
    output logic [7:0]         o_val
);

    logic [7:0]                  r_left;
    logic                        r_neg;
    logic [kcl_pkg::PROD_W-1:0]  r_quo;
    logic [15:0]                 r_rem;

    logic [8:0]                  diff;
    logic [7:0]                  diff_mag;
    logic [kcl_pkg::PROD_W-1:0]  prod;
    logic [16:0]                 trial;
    logic                        fits;

    always_comb begin
        diff     = {1'b0, i_right} - {1'b0, i_left};
        diff_mag = diff[8] ? 8'(~diff + 9'd1) : diff[7:0];
        prod     = {16'd0, diff_mag} * {8'd0, i_op.num_mag};
        trial    = {r_rem, r_quo[kcl_pkg::PROD_W-1]};
        fits     = (trial >= {1'b0, i_op.span_mag});
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_left <= i_left;
            r_neg  <= diff[8] ^ i_op.neg;
            r_quo  <= prod;
            r_rem  <= '0;
        end else if (i_ctl.step) begin
            r_rem <= fits ? 16'(trial - {1'b0, i_op.span_mag}) : trial[15:0];
            r_quo <= {r_quo[kcl_pkg::PROD_W-2:0], fits};
        end
    end

    // only the low byte of the quotient survives the wrap
    assign o_val = r_left + (r_neg ? (~r_quo[7:0] + 8'd1) : r_quo[7:0]);

endmodule

FILE: hw/rtl/kcl_checker.sv
// ----------------------------------------------------------------------------
// kcl_checker
// Port-level checks for keyframe_color_lerp, bound to the top level.
// ----------------------------------------------------------------------------
`include "keyframe_color_lerp_defines.svh"

module kcl_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           o_s_tready,
    input logic                           i_s_tuser,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [kcl_pkg::OUT_DATA_W-1:0] o_m_tdata
);

    logic s_acc;
    assign s_acc = i_s_tvalid && o_s_tready;

    `KCL_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata), "result dropped or changed while stalled")
    `KCL_ASSERT_NEXT(a_eval_busy, s_acc && (i_s_tuser == kcl_pkg::OP_EVAL), !o_s_tready, "evaluate item did not make the block busy")
    `KCL_ASSERT_NEXT(a_load_quick, s_acc && (i_s_tuser == kcl_pkg::OP_LOAD), o_s_tready, "load item stalled the input")
    `KCL_ASSERT_NOW(a_result_frees, $rose(o_m_tvalid), o_s_tready, "input not ready once a result is posted")

endmodule

bind keyframe_color_lerp kcl_checker u_kcl_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

FILE: sim/tb_keyframe_color_lerp.sv
// ----------------------------------------------------------------------------
// tb_keyframe_color_lerp
// Self-checking bench for the keyframe color interpolator. Loads key tables
// (mostly sorted, some scrambled), evaluates frames under several loop and
// key-count settings, and compares every result channel against a local
// integer predictor. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_keyframe_color_lerp;

    localparam int NKEYS       = kcl_pkg::MAX_KEYS_DEF;
    localparam int EVAL_CYCLES = NKEYS + 59;
    localparam int SETTLE      = EVAL_CYCLES + 8;
    localparam int QUIET_LIMIT = 4000;

    typedef struct {
        logic        op;
        logic [5:0]  idx;
        logic [15:0] pos;
        logic [31:0] prim_rgba;
        logic [7:0]  lod;
        logic [31:0] env_rgba;
        logic [31:0] frame;
        bit          drain;
    } t_kf_item;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_valid = 1'b0;
    logic [kcl_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic                           s_tuser = kcl_pkg::OP_LOAD;
    logic                           m_ready = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic [kcl_pkg::CFG_IDX_W-1:0]  cfg_index = kcl_pkg::CFG_LOOP_FRAMES;
    logic [kcl_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                           o_s_tready, o_m_tvalid, o_cfg_ready;
    logic [kcl_pkg::OUT_DATA_W-1:0] o_m_tdata;

    // predictor state
    logic [15:0]           cur_loop;
    logic [6:0]            cur_keys;
    logic [15:0]           key_pos  [NKEYS];
    logic [39:0]           key_prim [NKEYS];
    logic [31:0]           key_env  [NKEYS];
    logic [71:0]           colors_due [$];

    t_kf_item              pending_items [$];
    t_kf_item              cur_item;
    logic [15:0]           gen_pos [NKEYS];
    int                    gen_loop;
    bit                    rush;
    int                    gap_left, stall_left;
    bit                    stall_drawn;
    int                    errors, quiet_cycles;
    int                    n_loads, n_evals, n_checked, n_cfg;

    string chan_name [9] = '{"prim_red", "prim_green", "prim_blue", "prim_alpha",
        "prim_lod", "env_red", "env_green", "env_blue", "env_alpha"};

    keyframe_color_lerp u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_valid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_ready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_wait();
        return rush ? 0 : $urandom_range(0, 11);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        if (errors <= 50)
            $display("%0t ns: mismatch %s got %0h want %0h", $time, what, got, want);
    endtask

    // nine channels, prim_red in the low byte
    function automatic logic [71:0] lerp_colors(logic [31:0] frame);
        logic [31:0] len, t;
        int          n, hit, lk, rk, num, span, l, r, v;
        logic [71:0] lw, rw, res;
        len  = (cur_loop == 16'd0) ? 32'd1 : 32'(cur_loop);
        t    = frame % len;
        n    = (int'(cur_keys) > NKEYS) ? NKEYS : int'(cur_keys);
        hit  = 0;
        for (int i = 1; i < n; i++)
            if (hit == 0 && t < 32'(key_pos[i]))
                hit = i;
        if (hit != 0) begin
            lk   = hit - 1;
            rk   = hit;
            span = int'(key_pos[hit]) - int'(key_pos[hit-1]);
            num  = int'(t) - int'(key_pos[hit-1]);
        end else begin
            lk   = (n > 1) ? n - 1 : 0;
            rk   = lk;
            span = 1;
            num  = 0;
        end
        if (span == 0) begin
            rk   = lk;
            span = 1;
            num  = 0;
        end
        lw = {key_prim[lk], key_env[lk]};
        rw = {key_prim[rk], key_env[rk]};
        for (int c = 0; c < 9; c++) begin
            l = int'(lw[8*(8-c) +: 8]);
            r = int'(rw[8*(8-c) +: 8]);
            v = l + ((r - l) * num) / span;
            res[8*c +: 8] = v[7:0];
        end
        return res;
    endfunction

    function automatic void record_item(t_kf_item it);
        if (it.op == kcl_pkg::OP_LOAD) begin
            key_pos[it.idx]  = it.pos;
            key_prim[it.idx] = {it.prim_rgba, it.lod};
            key_env[it.idx]  = it.env_rgba;
            n_loads++;
        end else begin
            colors_due.push_back(lerp_colors(it.frame));
            n_evals++;
        end
    endfunction

    task automatic push_load(int e, int pos);
        t_kf_item it;
        it.op        = kcl_pkg::OP_LOAD;
        it.idx       = e[5:0];
        it.pos       = pos[15:0];
        it.prim_rgba = $urandom;
        it.lod       = 8'($urandom);
        it.env_rgba  = $urandom;
        it.frame     = $urandom;
        it.drain     = 1'b0;
        gen_pos[e]   = pos[15:0];
        pending_items.push_back(it);
    endtask

    task automatic push_eval(logic [31:0] frame, bit drain);
        t_kf_item it;
        it.op        = kcl_pkg::OP_EVAL;
        it.idx       = 6'($urandom);
        it.pos       = 16'($urandom);
        it.prim_rgba = $urandom;
        it.lod       = 8'($urandom);
        it.env_rgba  = $urandom;
        it.frame     = frame;
        it.drain     = drain;
        pending_items.push_back(it);
    endtask

    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (pending_items.size() != 0 || s_valid || colors_due.size() != 0);
    endtask

    task automatic write_reg(logic [kcl_pkg::CFG_IDX_W-1:0] idx, int value);
        wait_idle();
        repeat (SETTLE) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[kcl_pkg::CFG_DATA_W-1:0];
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == kcl_pkg::CFG_LOOP_FRAMES)
            cur_loop = value[15:0];
        else if (idx == kcl_pkg::CFG_KEYS_IN_USE)
            cur_keys = value[6:0];
        n_cfg++;
    endtask

    // driver: per-item gap, optional drain before an item
    always @(posedge i_clk) begin
        logic nxt_valid;
        nxt_valid = s_valid;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
            gap_left  = 0;
        end else begin
            if (s_valid && o_s_tready) begin
                record_item(cur_item);
                nxt_valid = 1'b0;
                gap_left  = pick_wait();
            end
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_items.size() != 0 &&
                             !(pending_items[0].drain && colors_due.size() != 0)) begin
                    cur_item  = pending_items.pop_front();
                    s_tdata  <= {2'b00, cur_item.frame, cur_item.env_rgba, cur_item.lod,
                                 cur_item.prim_rgba, cur_item.pos, cur_item.idx};
                    s_tuser  <= cur_item.op;
                    nxt_valid = 1'b1;
                end
            end
        end
        s_valid <= nxt_valid;
    end

    // monitor: stall drawn per presented result, random ready while empty
    always @(posedge i_clk) begin
        logic [71:0] want;
        logic        nxt_ready, took;
        took = o_m_tvalid && m_ready;
        if (!i_rst_n) begin
            nxt_ready   = 1'b0;
            stall_left  = 0;
            stall_drawn = 1'b0;
        end else begin
            if (took) begin
                n_checked++;
                stall_drawn = 1'b0;
                if (colors_due.size() == 0) begin
                    report_mismatch("result with nothing pending", o_m_tdata[31:0], 32'd0);
                end else begin
                    want = colors_due.pop_front();
                    for (int c = 0; c < 9; c++)
                        if (o_m_tdata[8*c +: 8] !== want[8*c +: 8])
                            report_mismatch(chan_name[c], 32'(o_m_tdata[8*c +: 8]),
                                            32'(want[8*c +: 8]));
                end
            end
            if (o_m_tvalid && !took) begin
                if (!stall_drawn) begin
                    stall_left  = pick_wait();
                    stall_drawn = 1'b1;
                end
                if (stall_left > 0) begin
                    stall_left--;
                    nxt_ready = 1'b0;
                end else begin
                    nxt_ready = 1'b1;
                end
            end else begin
                nxt_ready = rush ? 1'b1 : 1'($urandom_range(0, 1));
            end
        end
        m_ready <= nxt_ready;
    end

    always @(posedge i_clk) begin
        if ((s_valid && o_s_tready) || (o_m_tvalid && m_ready) || (cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int          lp, nk, step, acc, e, j, nkeys;
        bit          sorted;
        logic [31:0] frame;
        cur_loop = kcl_pkg::LOOP_FRAMES_RST;
        cur_keys = kcl_pkg::KEYS_IN_USE_RST;
        rush     = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, mid-span, zero span, past last key, unsorted keys
        write_reg(kcl_pkg::CFG_LOOP_FRAMES, 1);
        write_reg(kcl_pkg::CFG_KEYS_IN_USE, 2);
        push_load(0, 0);
        pending_items[$].prim_rgba = 32'h0000_0000;
        pending_items[$].lod       = 8'h00;
        pending_items[$].env_rgba  = 32'hFFFF_FFFF;
        push_load(1, 16'hFFFF);
        pending_items[$].prim_rgba = 32'hFFFF_FFFF;
        pending_items[$].lod       = 8'hFF;
        pending_items[$].env_rgba  = 32'h0000_0000;
        push_eval(32'd0, 1'b0);
        push_eval(32'hFFFF_FFFF, 1'b1);
        write_reg(kcl_pkg::CFG_LOOP_FRAMES, 65535);
        push_eval(32'd32768, 1'b0);
        push_eval(32'd65534, 1'b0);
        push_eval(32'hFFFF_FFFF, 1'b0);
        write_reg(kcl_pkg::CFG_LOOP_FRAMES, 0);
        push_eval(32'h1234_5678, 1'b0);
        write_reg(kcl_pkg::CFG_LOOP_FRAMES, 1000);
        push_load(0, 300);
        push_load(1, 300);
        push_eval(32'd200, 1'b0);
        push_eval(32'd500, 1'b0);
        push_load(0, 900);
        pending_items[$].prim_rgba = 32'h00FF_807F;
        pending_items[$].env_rgba  = 32'hFF00_7F80;
        push_eval(32'd100, 1'b0);
        write_reg(kcl_pkg::CFG_KEYS_IN_USE, 1);
        push_eval(32'd10, 1'b0);
        write_reg(kcl_pkg::CFG_KEYS_IN_USE, 0);
        push_eval(32'd10, 1'b0);

        // random phases; the first one fills the whole table
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin lp = 65535; nk = 64; end
                1: begin lp = $urandom_range(1, 300); nk = 2; end
                2: begin lp = $urandom_range(1, 65535); nk = $urandom_range(2, 64); end
                3: begin lp = $urandom_range(100, 4000); nk = 127; end
                4: begin lp = 1; nk = $urandom_range(3, 8); end
                default: begin lp = $urandom_range(1, 65535); nk = 64; end
            endcase
            write_reg(kcl_pkg::CFG_LOOP_FRAMES, lp);
            write_reg(kcl_pkg::CFG_KEYS_IN_USE, nk);
            rush     = (p % 3 == 2);
            gen_loop = lp;
            nkeys    = (nk > NKEYS) ? NKEYS : nk;
            if (p == 0 || $urandom_range(0, 1) == 1) begin
                sorted = (p == 0) || ($urandom_range(0, 4) != 0);
                step   = lp / nkeys + 1;
                acc    = $urandom_range(0, step);
                for (int k = 0; k < NKEYS; k++) begin
                    if (sorted) begin
                        push_load(k, acc);
                        acc += ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 2 * step);
                        if (acc > 65535)
                            acc = 65535;
                    end else begin
                        push_load(k, $urandom_range(0, 65535));
                    end
                end
            end
            for (int k = 0; k < 120; k++) begin
                if ($urandom_range(0, 9) < 3) begin
                    e = $urandom_range(0, 63);
                    push_load(e, ($urandom_range(0, 4) != 0) ? int'(gen_pos[e])
                                                            : $urandom_range(0, 65535));
                end else begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4: frame = $urandom;
                        5: frame = $urandom_range(0, 15);
                        default: begin
                            j     = $urandom_range(0, nkeys - 1);
                            frame = 32'(gen_loop) * 32'($urandom_range(0, 60000))
                                    + 32'(gen_pos[j]) + 32'($urandom_range(0, 2)) - 32'd1;
                        end
                    endcase
                    push_eval(frame, $urandom_range(0, 49) == 0);
                end
            end
        end

        wait_idle();
        repeat (SETTLE) @(posedge i_clk);
        $display("covered %0d table loads, %0d frame evaluations, %0d register writes",
                 n_loads, n_evals, n_cfg);
        $display("checked %0d results channel by channel, %0d mismatches", n_checked, errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
